>>> hw/rtl/cmq_pkg.sv
// Package for the cluster motion qualifier.
// Holds the strip and verdict word types, box state type and reason codes.
// No dependencies.
package cmq_pkg;

  localparam int COORD_BITS = 12;
  localparam int FRAC_BITS  = 10;
  localparam int FRAC_SHIFT = 8;
  localparam int IDX_BITS   = 2;
  localparam int CMP_BITS   = COORD_BITS + 4;

  localparam logic [FRAC_BITS-1:0] MIN_FRAC_RESET = '0;
  localparam logic [FRAC_BITS-1:0] MAX_FRAC_RESET = '1;

  typedef logic [COORD_BITS-1:0] coord_t;
  typedef logic [FRAC_BITS-1:0]  frac_t;

  typedef enum logic [IDX_BITS-1:0] {
    REG_MIN_MOTION = 2'd0,
    REG_MAX_MOTION = 2'd1
  } reg_index_t;

  typedef enum logic [2:0] {
    REASON_OK        = 3'd0,
    REASON_EMPTY     = 3'd1,
    REASON_LEFT      = 3'd2,
    REASON_RIGHT     = 3'd3,
    REASON_GAP1_LOW  = 3'd4,
    REASON_GAP1_HIGH = 3'd5,
    REASON_GAP2_LOW  = 3'd6,
    REASON_GAP2_HIGH = 3'd7
  } reason_t;

  typedef struct packed {
    coord_t     strip_x;
    coord_t     strip_y;
    logic       lit_in_first;
    logic       lit_in_second;
    logic       last_strip;
    coord_t     cluster_left_x;
    coord_t     cluster_right_x;
  } strip_word_t;

  typedef struct packed {
    logic       is_object;
    logic [2:0] reject_reason;
    coord_t     object_center_x;
    coord_t     object_center_y;
    coord_t     previous_center_x;
    coord_t     previous_center_y;
  } verdict_word_t;

  typedef struct packed {
    coord_t min_x;
    coord_t min_y;
    coord_t max_x;
    coord_t max_y;
    logic   seen;
  } box_t;

  typedef struct packed {
    logic advance;
    logic last;
  } step_ctl_t;

  localparam box_t BOX_EMPTY = '{min_x: '1, min_y: '1, max_x: '0, max_y: '0, seen: 1'b0};

endpackage

>>> hw/rtl/cluster_motion_qualifier_core.sv
// Top level of the cluster motion qualifier.
// Instantiates cmq_box_tracker and cmq_verdict; depends on cmq_pkg.
//
// Strips of one cluster arrive in order on the strip channel, one word per
// strip, accepted when strip_valid is high and strip_stall is low. Each word
// lands in an input register and is folded into the two bounding boxes once
// it advances. The word that carries last_strip also produces one verdict word
// on the verdict channel; other strips produce nothing.
// A verdict passes through the input register and then the verdict register
// on its way to the verdict channel. One strip can be accepted every cycle;
// the only limit is the verdict register, which holds one word.
// When the receiver stalls with a verdict waiting, strips that do not end a
// cluster keep flowing; a final strip waits in the input register, and only
// then is strip_stall raised.
// The configuration channel is always ready; index 0 writes the minimum and
// index 1 the maximum motion fraction, other indexes are ignored. Write it
// only while the block is idle.
// Reset is synchronous: it empties both registers and both boxes and restores
// the motion fractions to their defaults.
module cluster_motion_qualifier_core (
  input  logic                     clk,
  input  logic                     rst,
  input  logic                     strip_valid,
  output logic                     strip_stall,
  input  cmq_pkg::strip_word_t     strip,
  output logic                     verdict_valid,
  input  logic                     verdict_stall,
  output cmq_pkg::verdict_word_t   verdict,
  input  logic                     cfg_valid,
  output logic                     cfg_ready,
  input  logic [cmq_pkg::IDX_BITS-1:0] cfg_index,
  input  logic [cmq_pkg::FRAC_BITS-1:0] cfg_data
);
  import cmq_pkg::*;

  strip_word_t   held;
  logic          held_valid;
  frac_t         min_frac;
  frac_t         max_frac;
  step_ctl_t     ctl;
  box_t          first_box;
  box_t          second_box;
  verdict_word_t verdict_next;
  logic          out_free;

  assign out_free    = !verdict_valid || !verdict_stall;
  assign ctl.advance = held_valid && (!held.last_strip || out_free);
  assign ctl.last    = held.last_strip;
  assign strip_stall = held_valid && !ctl.advance;
  assign cfg_ready   = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      held_valid <= 1'b0;
    end else if (!strip_stall) begin
      held_valid <= strip_valid;
    end
    if (!strip_stall && strip_valid) begin
      held <= strip;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      min_frac <= MIN_FRAC_RESET;
      max_frac <= MAX_FRAC_RESET;
    end else if (cfg_valid && cfg_ready) begin
      if (cfg_index == REG_MIN_MOTION) min_frac <= cfg_data;
      if (cfg_index == REG_MAX_MOTION) max_frac <= cfg_data;
    end
  end

  cmq_box_tracker u_boxes (
    .clk        (clk),
    .rst        (rst),
    .ctl        (ctl),
    .word       (held),
    .first_box  (first_box),
    .second_box (second_box)
  );

  cmq_verdict u_verdict (
    .first_box  (first_box),
    .second_box (second_box),
    .left_x     (held.cluster_left_x),
    .right_x    (held.cluster_right_x),
    .min_frac   (min_frac),
    .max_frac   (max_frac),
    .verdict    (verdict_next)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      verdict_valid <= 1'b0;
    end else if (ctl.advance && ctl.last) begin
      verdict_valid <= 1'b1;
    end else if (!verdict_stall) begin
      verdict_valid <= 1'b0;
    end
    if (ctl.advance && ctl.last) begin
      verdict <= verdict_next;
    end
  end

endmodule

>>> hw/rtl/cmq_box_tracker.sv
// Bounding box registers for both difference images.
// Presents the boxes widened by the current strip; depends on cmq_pkg.
module cmq_box_tracker (
  input  logic                clk,
  input  logic                rst,
  input  cmq_pkg::step_ctl_t  ctl,
  input  cmq_pkg::strip_word_t word,
  output cmq_pkg::box_t       first_box,
  output cmq_pkg::box_t       second_box
);
  import cmq_pkg::*;

  box_t first_state;
  box_t second_state;

  function automatic box_t widen(input box_t b, input coord_t x, input coord_t y);
    box_t r;
    r = b;
    if (x < b.min_x) r.min_x = x;
    if (y < b.min_y) r.min_y = y;
    if (x > b.max_x) r.max_x = x;
    if (y > b.max_y) r.max_y = y;
    r.seen = 1'b1;
    return r;
  endfunction

  assign first_box  = word.lit_in_first ? widen(first_state, word.strip_x, word.strip_y)
                                        : first_state;
  assign second_box = word.lit_in_second ? widen(second_state, word.strip_x, word.strip_y)
                                         : second_state;

  always_ff @(posedge clk) begin
    if (rst) begin
      first_state  <= BOX_EMPTY;
      second_state <= BOX_EMPTY;
    end else if (ctl.advance) begin
      if (ctl.last) begin
        first_state  <= BOX_EMPTY;
        second_state <= BOX_EMPTY;
      end else begin
        first_state  <= first_box;
        second_state <= second_box;
      end
    end
  end

endmodule

>>> hw/rtl/cmq_verdict.sv
// Object test on the two widened boxes of a finished cluster.
// Produces the verdict word; depends on cmq_pkg.
module cmq_verdict (
  input  cmq_pkg::box_t         first_box,
  input  cmq_pkg::box_t         second_box,
  input  cmq_pkg::coord_t       left_x,
  input  cmq_pkg::coord_t       right_x,
  input  cmq_pkg::frac_t        min_frac,
  input  cmq_pkg::frac_t        max_frac,
  output cmq_pkg::verdict_word_t verdict
);
  import cmq_pkg::*;

  localparam int W_BITS    = COORD_BITS + 1;
  localparam int PROD_BITS = FRAC_BITS + COORD_BITS;
  localparam int Q_BITS    = PROD_BITS - FRAC_SHIFT;

  box_t                       box_a;
  box_t                       box_b;
  logic                       empty;
  logic signed [W_BITS-1:0]   width;
  logic        [W_BITS-1:0]   width_abs;
  coord_t                     width_mag;
  logic        [PROD_BITS-1:0] prod_lo;
  logic        [PROD_BITS-1:0] prod_hi;
  logic        [Q_BITS-1:0]   q_lo;
  logic        [Q_BITS-1:0]   q_hi;
  logic signed [CMP_BITS-1:0] lim_lo;
  logic signed [CMP_BITS-1:0] lim_hi;
  logic signed [CMP_BITS-1:0] gap1;
  logic signed [CMP_BITS-1:0] gap2;
  reason_t                    reason;
  logic        [COORD_BITS:0] sum_ax;
  logic        [COORD_BITS:0] sum_ay;
  logic        [COORD_BITS:0] sum_bx;
  logic        [COORD_BITS:0] sum_by;

  always_comb begin
    empty = !(first_box.seen && second_box.seen);
    if (first_box.min_x != left_x) begin
      box_a = second_box;
      box_b = first_box;
    end else begin
      box_a = first_box;
      box_b = second_box;
    end

    width     = $signed({1'b0, right_x}) - $signed({1'b0, left_x});
    width_abs = width[W_BITS-1] ? W_BITS'(-width) : W_BITS'(width);
    width_mag = width_abs[COORD_BITS-1:0];
    prod_lo   = PROD_BITS'(min_frac) * PROD_BITS'(width_mag);
    prod_hi   = PROD_BITS'(max_frac) * PROD_BITS'(width_mag);
    q_lo      = prod_lo[PROD_BITS-1:FRAC_SHIFT];
    q_hi      = prod_hi[PROD_BITS-1:FRAC_SHIFT];
    lim_lo    = width[W_BITS-1] ? -$signed(CMP_BITS'(q_lo)) : $signed(CMP_BITS'(q_lo));
    lim_hi    = width[W_BITS-1] ? -$signed(CMP_BITS'(q_hi)) : $signed(CMP_BITS'(q_hi));

    gap1 = $signed(CMP_BITS'(right_x)) - $signed(CMP_BITS'(box_a.max_x));
    gap2 = $signed(CMP_BITS'(box_b.min_x)) - $signed(CMP_BITS'(left_x));

    if (empty)                      reason = REASON_EMPTY;
    else if (box_a.min_x != left_x)  reason = REASON_LEFT;
    else if (box_b.max_x != right_x) reason = REASON_RIGHT;
    else if (gap1 < lim_lo)          reason = REASON_GAP1_LOW;
    else if (gap1 > lim_hi)          reason = REASON_GAP1_HIGH;
    else if (gap2 < lim_lo)          reason = REASON_GAP2_LOW;
    else if (gap2 > lim_hi)          reason = REASON_GAP2_HIGH;
    else                             reason = REASON_OK;

    sum_ax = {1'b0, box_a.min_x} + {1'b0, box_a.max_x};
    sum_ay = {1'b0, box_a.min_y} + {1'b0, box_a.max_y};
    sum_bx = {1'b0, box_b.min_x} + {1'b0, box_b.max_x};
    sum_by = {1'b0, box_b.min_y} + {1'b0, box_b.max_y};

    verdict.is_object     = (reason == REASON_OK);
    verdict.reject_reason = reason;
    if (empty) begin
      verdict.object_center_x   = '0;
      verdict.object_center_y   = '0;
      verdict.previous_center_x = '0;
      verdict.previous_center_y = '0;
    end else begin
      verdict.object_center_x   = sum_ax[COORD_BITS:1];
      verdict.object_center_y   = sum_ay[COORD_BITS:1];
      verdict.previous_center_x = sum_bx[COORD_BITS:1];
      verdict.previous_center_y = sum_by[COORD_BITS:1];
    end
  end

endmodule

>>> bench/cmq_verdict_checker.sv
// Checker for the cluster motion qualifier: watches the strip, verdict and
// configuration channels, predicts each verdict word and compares it.
// Depends on cmq_pkg.
`timescale 1ns / 1ps

module cmq_verdict_checker (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          strip_valid,
  input  logic                          strip_stall,
  input  cmq_pkg::strip_word_t          strip,
  input  logic                          verdict_valid,
  input  logic                          verdict_stall,
  input  cmq_pkg::verdict_word_t        verdict,
  input  logic                          cfg_valid,
  input  logic                          cfg_ready,
  input  logic [cmq_pkg::IDX_BITS-1:0]  cfg_index,
  input  logic [cmq_pkg::FRAC_BITS-1:0] cfg_data,
  output int unsigned                   pending_verdicts,
  output int unsigned                   failures
);
  import cmq_pkg::*;

  frac_t         min_frac;
  frac_t         max_frac;
  box_t          boxes [2];
  verdict_word_t expected_verdicts [$];
  verdict_word_t oldest;
  int unsigned   mismatch_total = 0;

  function automatic int motion_bound(frac_t frac, int width);
    int mag;
    int q;
    mag = (width < 0) ? -width : width;
    q = (int'(frac) * mag) >>> FRAC_SHIFT;
    return (width < 0) ? -q : q;
  endfunction

  function automatic coord_t midpoint(coord_t lo, coord_t hi);
    logic [COORD_BITS:0] sum;
    sum = {1'b0, lo} + {1'b0, hi};
    return sum[COORD_BITS:1];
  endfunction

  task automatic widen_box(int i, coord_t x, coord_t y);
    if (x < boxes[i].min_x) boxes[i].min_x = x;
    if (y < boxes[i].min_y) boxes[i].min_y = y;
    if (x > boxes[i].max_x) boxes[i].max_x = x;
    if (y > boxes[i].max_y) boxes[i].max_y = y;
    boxes[i].seen = 1'b1;
  endtask

  task automatic fold_strip(strip_word_t s);
    verdict_word_t v;
    reason_t       why;
    int            first;
    int            second;
    int            width;
    int            lo;
    int            hi;
    int            gap1;
    int            gap2;
    if (s.lit_in_first) widen_box(0, s.strip_x, s.strip_y);
    if (s.lit_in_second) widen_box(1, s.strip_x, s.strip_y);
    if (s.last_strip) begin
      v = '0;
      if (!boxes[0].seen || !boxes[1].seen) begin
        v.reject_reason = REASON_EMPTY;
      end else begin
        first = (boxes[0].min_x != s.cluster_left_x) ? 1 : 0;
        second = 1 - first;
        width = int'(s.cluster_right_x) - int'(s.cluster_left_x);
        lo = motion_bound(min_frac, width);
        hi = motion_bound(max_frac, width);
        gap1 = int'(s.cluster_right_x) - int'(boxes[first].max_x);
        gap2 = int'(boxes[second].min_x) - int'(s.cluster_left_x);
        if (boxes[first].min_x != s.cluster_left_x) why = REASON_LEFT;
        else if (boxes[second].max_x != s.cluster_right_x) why = REASON_RIGHT;
        else if (gap1 < lo) why = REASON_GAP1_LOW;
        else if (gap1 > hi) why = REASON_GAP1_HIGH;
        else if (gap2 < lo) why = REASON_GAP2_LOW;
        else if (gap2 > hi) why = REASON_GAP2_HIGH;
        else why = REASON_OK;
        v.is_object = (why == REASON_OK);
        v.reject_reason = why;
        v.object_center_x = midpoint(boxes[first].min_x, boxes[first].max_x);
        v.object_center_y = midpoint(boxes[first].min_y, boxes[first].max_y);
        v.previous_center_x = midpoint(boxes[second].min_x, boxes[second].max_x);
        v.previous_center_y = midpoint(boxes[second].min_y, boxes[second].max_y);
      end
      expected_verdicts = {expected_verdicts, v};
      boxes[0] = BOX_EMPTY;
      boxes[1] = BOX_EMPTY;
    end
  endtask

  always @(posedge clk) begin
    if (rst) begin
      min_frac = MIN_FRAC_RESET;
      max_frac = MAX_FRAC_RESET;
      boxes[0] = BOX_EMPTY;
      boxes[1] = BOX_EMPTY;
      expected_verdicts.delete();
    end else begin
      if (cfg_valid && cfg_ready) begin
        if (cfg_index == REG_MIN_MOTION) min_frac = cfg_data;
        else if (cfg_index == REG_MAX_MOTION) max_frac = cfg_data;
      end
      if (verdict_valid && !verdict_stall) begin
        if (expected_verdicts.size() == 0) begin
          mismatch_total++;
          if (mismatch_total <= 10)
            $display("verdict word with none expected: obj=%0d reason=%0d", verdict.is_object,
                     verdict.reject_reason);
        end else begin
          oldest = expected_verdicts.pop_front();
          if (verdict !== oldest) begin
            mismatch_total++;
            if (mismatch_total <= 10) begin
              $display("mismatch: expected obj=%0d reason=%0d cur=(%0d,%0d) prev=(%0d,%0d)",
                       oldest.is_object, oldest.reject_reason, oldest.object_center_x,
                       oldest.object_center_y, oldest.previous_center_x,
                       oldest.previous_center_y);
              $display("          actual   obj=%0d reason=%0d cur=(%0d,%0d) prev=(%0d,%0d)",
                       verdict.is_object, verdict.reject_reason, verdict.object_center_x,
                       verdict.object_center_y, verdict.previous_center_x,
                       verdict.previous_center_y);
            end
          end
        end
      end
      if (strip_valid && !strip_stall) fold_strip(strip);
    end
    pending_verdicts <= expected_verdicts.size();
    failures <= mismatch_total;
  end

endmodule

>>> bench/cluster_motion_qualifier_core_tb.sv
// Testbench top for cluster_motion_qualifier_core: drives strips, verdict
// stalls and register writes, and takes the verdict from cmq_verdict_checker.
// Depends on cmq_pkg, the core and the checker.
`timescale 1ns / 1ps

module cluster_motion_qualifier_core_tb;
  import cmq_pkg::*;

  localparam int          LIMIT_CYCLES  = 200000;
  localparam int          HOLD_CYCLES   = 300;
  localparam int          SETTLE_CYCLES = 4;
  localparam int          PHASES        = 8;
  localparam int          PHASE_STRIPS  = 140;
  localparam int          IDLE_PCT      = 31;
  localparam logic [IDX_BITS-1:0] REG_SPARE_LO = 2'd2;
  localparam logic [IDX_BITS-1:0] REG_SPARE_HI = 2'd3;

  logic                 clk = 1'b0;
  logic                 rst = 1'b1;
  logic                 strip_valid = 1'b0;
  logic                 strip_stall;
  strip_word_t          strip = '0;
  logic                 verdict_valid;
  logic                 verdict_stall = 1'b0;
  verdict_word_t        verdict;
  logic                 cfg_valid = 1'b0;
  logic                 cfg_ready;
  logic [IDX_BITS-1:0]  cfg_index = '0;
  logic [FRAC_BITS-1:0] cfg_data = '0;
  int unsigned          pending_verdicts;
  int unsigned          failures;

  logic                 idle_on = 1'b1;
  logic                 hold_active = 1'b0;
  int unsigned          hold_count = 0;
  int unsigned          cycle_count = 0;
  int unsigned          phase_strips = 0;

  cluster_motion_qualifier_core i_dut (.*);
  cmq_verdict_checker i_checker (.*);

  always #5 clk = ~clk;

  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count >= LIMIT_CYCLES) begin
      $display("RESULT: ERROR");
      $finish;
    end
  end

  always @(posedge clk) begin
    if (rst) begin
      verdict_stall <= 1'b0;
      hold_count <= 0;
    end else if (hold_active && hold_count < HOLD_CYCLES) begin
      verdict_stall <= 1'b1;
      hold_count <= hold_count + 1;
    end else begin
      verdict_stall <= idle_on && ($urandom_range(99) < IDLE_PCT);
    end
  end

  function automatic strip_word_t strip_at(int x, int y, bit f, bit s);
    strip_word_t w;
    w.strip_x = coord_t'(x);
    w.strip_y = coord_t'(y);
    w.lit_in_first = f;
    w.lit_in_second = s;
    w.last_strip = 1'b0;
    w.cluster_left_x = coord_t'($urandom);
    w.cluster_right_x = coord_t'($urandom);
    return w;
  endfunction

  task automatic send_strip(strip_word_t w);
    while (idle_on && $urandom_range(99) < IDLE_PCT) begin
      strip_valid <= 1'b0;
      @(posedge clk);
    end
    strip_valid <= 1'b1;
    strip <= w;
    do @(posedge clk); while (strip_stall);
    phase_strips++;
  endtask

  task automatic send_final(int x, int y, bit f, bit s, int left, int right);
    strip_word_t w;
    w = strip_at(x, y, f, s);
    w.last_strip = 1'b1;
    w.cluster_left_x = coord_t'(left);
    w.cluster_right_x = coord_t'(right);
    send_strip(w);
  endtask

  task automatic wait_idle();
    do @(posedge clk); while (pending_verdicts != 0);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  task automatic write_reg(logic [IDX_BITS-1:0] idx, frac_t val);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data <= val;
    do @(posedge clk); while (!cfg_ready);
  endtask

  task automatic set_motion(frac_t lo, frac_t hi);
    wait_idle();
    write_reg(REG_MIN_MOTION, lo);
    write_reg(REG_MAX_MOTION, hi);
    write_reg($urandom_range(1) ? REG_SPARE_LO : REG_SPARE_HI, frac_t'($urandom));
    cfg_valid <= 1'b0;
  endtask

  // Most clusters are well formed: one box spans the left edge, the other the
  // right edge, with random gaps. A few get an empty box or a wrong edge.
  task automatic send_random_cluster();
    strip_word_t parts [$];
    strip_word_t tmp;
    int          xs [$];
    int          left;
    int          right;
    int          a_max;
    int          b_min;
    int          k;
    int          j;
    int          roll;
    int          fault;
    bit          swap;
    bit          in_a;
    bit          in_b;
    roll = $urandom_range(99);
    fault = $urandom_range(99);
    left = $urandom_range(4095);
    if (roll < 10) begin
      right = $urandom_range(4095);
    end else if (roll < 55) begin
      right = left + $urandom_range(300);
      if (right > 4095) right = 4095;
    end else begin
      right = $urandom_range(4095, left);
    end
    if (right >= left) begin
      a_max = right - $urandom_range(right - left);
      b_min = left + $urandom_range(right - left);
    end else begin
      a_max = $urandom_range(4095, left);
      b_min = $urandom_range(right);
    end
    swap = 1'($urandom_range(1));
    xs = '{left, a_max, b_min, right};
    repeat ($urandom_range(3)) begin
      if ($urandom_range(1)) xs = {xs, int'($urandom_range(a_max, left))};
      else xs = {xs, int'($urandom_range(right, b_min))};
    end
    foreach (xs[i]) begin
      in_a = xs[i] >= left && xs[i] <= a_max;
      in_b = xs[i] >= b_min && xs[i] <= right;
      parts = {parts, strip_at(xs[i], $urandom_range(4095), swap ? in_b : in_a,
                               swap ? in_a : in_b)};
    end
    repeat ($urandom_range(1)) parts = {parts, strip_at($urandom_range(4095),
                                                        $urandom_range(4095), 1'b0, 1'b0)};
    foreach (parts[i]) begin
      if (fault < 6) parts[i].lit_in_first = 1'b0;
      else if (fault < 10) parts[i].lit_in_second = 1'b0;
      else if (fault >= 18 && fault < 22) begin
        parts[i].lit_in_first = 1'($urandom_range(1));
        parts[i].lit_in_second = 1'($urandom_range(1));
      end
    end
    for (k = parts.size() - 1; k > 0; k--) begin
      j = $urandom_range(k);
      tmp = parts[k];
      parts[k] = parts[j];
      parts[j] = tmp;
    end
    tmp = parts[parts.size() - 1];
    tmp.last_strip = 1'b1;
    tmp.cluster_left_x = coord_t'(left);
    tmp.cluster_right_x = coord_t'(right);
    if (fault >= 10 && fault < 14)
      tmp.cluster_left_x = tmp.cluster_left_x ^ (coord_t'(1) << $urandom_range(11));
    else if (fault >= 14 && fault < 18)
      tmp.cluster_right_x = tmp.cluster_right_x ^ (coord_t'(1) << $urandom_range(11));
    parts[parts.size() - 1] = tmp;
    foreach (parts[i]) send_strip(parts[i]);
  endtask

  initial begin
    int p;
    repeat (5) @(posedge clk);
    rst <= 1'b0;

    set_motion('0, '1);
    send_final(0, 0, 1'b0, 1'b0, 0, 0);
    send_strip(strip_at(5, 5, 1'b1, 1'b0));
    send_final(7, 7, 1'b1, 1'b0, 5, 7);
    send_strip(strip_at(100, 50, 1'b1, 1'b0));
    send_strip(strip_at(120, 4095, 1'b1, 1'b0));
    send_strip(strip_at(180, 0, 1'b0, 1'b1));
    send_final(200, 80, 1'b0, 1'b1, 100, 200);
    send_strip(strip_at(100, 50, 1'b0, 1'b1));
    send_strip(strip_at(120, 4095, 1'b0, 1'b1));
    send_strip(strip_at(180, 0, 1'b1, 1'b0));
    send_final(200, 80, 1'b1, 1'b0, 100, 200);
    send_strip(strip_at(0, 0, 1'b1, 1'b1));
    send_strip(strip_at(4095, 4095, 1'b1, 1'b1));
    send_final(2048, 2048, 1'b1, 1'b1, 1, 4095);
    send_strip(strip_at(0, 9, 1'b1, 1'b0));
    send_final(4000, 9, 1'b0, 1'b1, 0, 4095);
    send_strip(strip_at(3000, 20, 1'b1, 1'b0));
    send_final(1000, 30, 1'b0, 1'b1, 3000, 1000);
    strip_valid <= 1'b0;

    set_motion(10'd128, 10'd128);
    send_strip(strip_at(0, 1, 1'b1, 1'b0));
    send_final(256, 1, 1'b0, 1'b1, 0, 256);
    send_strip(strip_at(0, 2, 1'b1, 1'b0));
    send_strip(strip_at(128, 2, 1'b1, 1'b0));
    send_strip(strip_at(100, 3, 1'b0, 1'b1));
    send_final(256, 3, 1'b0, 1'b1, 0, 256);
    strip_valid <= 1'b0;

    for (p = 0; p < PHASES; p++) begin
      idle_on <= (p != 4);
      case (p)
        0: set_motion('1, '1);
        1: set_motion('0, '0);
        2: set_motion('1, '0);
        3: set_motion('0, '1);
        default: set_motion(frac_t'($urandom_range(200)), frac_t'($urandom_range(600, 100)));
      endcase
      if (p == 5) hold_active <= 1'b1;
      phase_strips = 0;
      while (phase_strips < PHASE_STRIPS) send_random_cluster();
      strip_valid <= 1'b0;
    end

    wait_idle();
    if (failures == 0) begin
      $display("RESULT: OK");
    end else begin
      $display("RESULT: ERROR");
    end
    $finish;
  end

endmodule
